// ===== rtl/dfs_pkg.sv =====
// Shared types, constants and neighbor helpers for the depth-first maze explorer.
// No dependencies; dfs_maze_explorer and the testbench import this package.
package dfs_pkg;

  // Maze and stack dimensions.
  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int STACK_DEPTH = 1024;

  // Widths that follow from the dimensions and from the item fields.
  localparam int POS_W     = 5;
  localparam int SIZE_W    = 6;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int COL_AW    = $clog2(MAX_COLS);
  localparam int ROW_BITS  = 2 * MAX_COLS;
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] ROWS_CAP  = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_CAP  = SIZE_W'(MAX_COLS);
  localparam logic [CNT_W-1:0]  STACK_CAP = CNT_W'(STACK_DEPTH);

  // Map cell codes.
  typedef enum logic [1:0] {
    CELL_UNKNOWN = 2'd0,
    CELL_WALL    = 2'd1,
    CELL_ROOM    = 2'd2,
    CELL_VISITED = 2'd3
  } cell_e;

  // Move directions, also the order in which free rooms are tried.
  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } dir_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_MOVE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    RESP_IMPOSSIBLE = 2'd0,
    RESP_OK         = 2'd1,
    RESP_EXITED     = 2'd2,
    RESP_NOT_NOW    = 2'd3
  } resp_e;

  typedef enum logic [1:0] {
    STAT_MOVE      = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_EXITED    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 2'd0,
    CFG_GRID_COLS = 2'd1,
    CFG_START_ROW = 2'd2,
    CFG_START_COL = 2'd3
  } cfg_idx_e;

  // Kind of request being worked on.
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_IMP   = 2'd1,
    MODE_OK    = 2'd2,
    MODE_EXIT  = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_RD_N,
    S_RD_C,
    S_RD_S,
    S_CAP,
    S_CALC,
    S_WR_N,
    S_WR_C,
    S_WR_S
  } state_e;

  // One map row: a 2-bit code per column.
  typedef logic [MAX_COLS-1:0][1:0] map_row_t;

  // Request and result payloads.
  typedef struct packed {
    logic       func;
    logic [1:0] response;
    logic       north_wall;
    logic       south_wall;
    logic       west_wall;
    logic       east_wall;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       direction;
    logic             backtracked;
    logic [POS_W-1:0] pos_row;
    logic [POS_W-1:0] pos_col;
  } out_item_t;

  // True when the neighbor of (r,c) in direction d lies on the grid in use.
  function automatic logic nbr_valid(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                                     input logic [1:0] d, input logic [SIZE_W-1:0] rows,
                                     input logic [SIZE_W-1:0] cols);
    logic [SIZE_W-1:0] r6;
    logic [SIZE_W-1:0] c6;
    logic              v;
    r6 = SIZE_W'(r);
    c6 = SIZE_W'(c);
    unique case (d)
      DIR_N:   v = (r != '0) && ((r6 - 1'b1) < rows) && (c6 < cols);
      DIR_S:   v = ((r6 + 1'b1) < rows) && (c6 < cols);
      DIR_W:   v = (c != '0) && (r6 < rows) && ((c6 - 1'b1) < cols);
      default: v = (r6 < rows) && ((c6 + 1'b1) < cols);
    endcase
    return v;
  endfunction

  // Coordinates of the neighbor of (r,c) in direction d, row in the upper half.
  function automatic logic [2*POS_W-1:0] nbr_pos(input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c,
                                                 input logic [1:0] d);
    logic [POS_W-1:0] tr;
    logic [POS_W-1:0] tc;
    tr = r;
    tc = c;
    unique case (d)
      DIR_N:   tr = r - 1'b1;
      DIR_S:   tr = r + 1'b1;
      DIR_W:   tc = c - 1'b1;
      default: tc = c + 1'b1;
    endcase
    return {tr, tc};
  endfunction

endpackage

// ===== rtl/dfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dfs_maze_explorer.sv =====
// Top level of the depth-first maze explorer: sequencer, map row update and move choice.
// Depends on dfs_pkg and on dfs_ram for the map and the backtrack stack.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//  out      | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A move request goes from acceptance to the result register through three map row
// reads, a step that captures the last row and the stack top, one that updates the rows
// and chooses the move, and three row write-backs. The next request can be taken in the
// cycle after the result is loaded. A start request first clears the map, one row a cycle.
// After reset the same clearing pass runs over every map row before any request is taken.
// A stalled result holds the block in its last write-back cycle until the slot frees.
module dfs_maze_explorer
  import dfs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [SIZE_W-1:0] grid_rows_q;
  logic [SIZE_W-1:0] grid_cols_q;
  logic [POS_W-1:0]  start_row_q;
  logic [POS_W-1:0]  start_col_q;

  // Explorer state.
  state_e            state_q, state_d;
  mode_e             mode_q;
  logic [POS_W-1:0]  cur_row_q;
  logic [POS_W-1:0]  cur_col_q;
  logic [1:0]        last_dir_q;
  logic              pushed_q;
  logic [CNT_W-1:0]  count_q;
  logic [3:0]        walls_q;
  logic [ROW_AW-1:0] clr_cnt_q;

  // Row buffers: read data first, modified data after the calculation cycle.
  map_row_t          row_n_q;
  map_row_t          row_c_q;
  map_row_t          row_s_q;
  logic [3:0]        nv_q;
  logic [1:0]        stk_top_q;
  out_item_t         res_q;

  // Output register.
  logic              out_valid_q;
  out_item_t         out_data_q;

  // Memory ports.
  logic              map_we;
  logic [ROW_AW-1:0] map_waddr;
  map_row_t          map_wdata;
  logic              map_re;
  logic [ROW_AW-1:0] map_raddr;
  map_row_t          map_rdata;
  logic              stk_we;
  logic              stk_re;
  logic [1:0]        stk_rdata;

  // Sequencer outputs.
  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              clr_last;

  // Effective grid size and start cell.
  logic [SIZE_W-1:0] eff_rows;
  logic [SIZE_W-1:0] eff_cols;
  logic [POS_W-1:0]  start_row_eff;
  logic [POS_W-1:0]  start_col_eff;

  // Target of the last issued move, seen from the current cell.
  logic              tgt_ok;
  logic [2*POS_W-1:0] tgt_pos;

  // Neighbor evaluation in the calculation cycle.
  logic [3:0]        nv;
  logic [3:0][1:0]   nb_old;
  logic [3:0][1:0]   nb_new;
  logic [3:0]        room;
  logic [POS_W-1:0]  col_w;
  logic [POS_W-1:0]  col_e;
  map_row_t          new_n;
  map_row_t          new_c;
  map_row_t          new_s;
  logic              found;
  logic [1:0]        pick;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign clr_last    = (clr_cnt_q == ROW_AW'(MAX_ROWS - 1));

  // Grid size saturates to one and to the map size; the start cell to the last row/column.
  always_comb begin
    if (grid_rows_q == '0) begin
      eff_rows = SIZE_W'(1);
    end else if (grid_rows_q > ROWS_CAP) begin
      eff_rows = ROWS_CAP;
    end else begin
      eff_rows = grid_rows_q;
    end
    if (grid_cols_q == '0) begin
      eff_cols = SIZE_W'(1);
    end else if (grid_cols_q > COLS_CAP) begin
      eff_cols = COLS_CAP;
    end else begin
      eff_cols = grid_cols_q;
    end
    start_row_eff = (SIZE_W'(start_row_q) < eff_rows) ? start_row_q : POS_W'(eff_rows - 1'b1);
    start_col_eff = (SIZE_W'(start_col_q) < eff_cols) ? start_col_q : POS_W'(eff_cols - 1'b1);
  end

  assign tgt_ok  = nbr_valid(cur_row_q, cur_col_q, last_dir_q, eff_rows, eff_cols);
  assign tgt_pos = nbr_pos(cur_row_q, cur_col_q, last_dir_q);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= SIZE_W'(32);
      grid_cols_q <= SIZE_W'(32);
      start_row_q <= '0;
      start_col_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
        CFG_START_ROW: start_row_q <= cfg_data_i[POS_W-1:0];
        default:       start_col_q <= cfg_data_i[POS_W-1:0];
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.func == FUNC_START) begin
            state_d = S_CLEAR;
          end else if (in_data_i.response != RESP_NOT_NOW) begin
            state_d = S_RD_N;
          end
        end
      end
      S_CLEAR: begin
        if (clr_last) state_d = S_RD_N;
      end
      S_RD_N: state_d = S_RD_C;
      S_RD_C: state_d = S_RD_S;
      S_RD_S: state_d = S_CAP;
      S_CAP:  state_d = S_CALC;
      S_CALC: state_d = S_WR_N;
      S_WR_N: state_d = S_WR_C;
      S_WR_C: state_d = S_WR_S;
      S_WR_S: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  // Sequencer outputs: memory ports and handshake.
  always_comb begin
    in_stall_o = 1'b1;
    map_we     = 1'b0;
    map_waddr  = ROW_AW'(cur_row_q);
    map_wdata  = row_c_q;
    map_re     = 1'b0;
    map_raddr  = ROW_AW'(cur_row_q);
    stk_re     = 1'b0;
    stk_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q) inside
      S_INIT, S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt_q;
        map_wdata = '0;
      end
      S_IDLE: in_stall_o = 1'b0;
      S_RD_N: begin
        map_re    = 1'b1;
        map_raddr = ROW_AW'(cur_row_q - 1'b1);
      end
      S_RD_C: map_re = 1'b1;
      S_RD_S: begin
        map_re    = 1'b1;
        map_raddr = ROW_AW'(cur_row_q + 1'b1);
        stk_re    = 1'b1;
      end
      S_CALC: stk_we = found && (mode_q != MODE_EXIT) && (count_q < STACK_CAP);
      S_WR_N: begin
        map_we    = nv_q[DIR_N];
        map_waddr = ROW_AW'(cur_row_q - 1'b1);
        map_wdata = row_n_q;
      end
      S_WR_C: map_we = 1'b1;
      S_WR_S: begin
        map_we    = nv_q[DIR_S];
        map_waddr = ROW_AW'(cur_row_q + 1'b1);
        map_wdata = row_s_q;
        load_out  = out_free;
      end
      default: ;
    endcase
  end

  // Neighbor cells, their updated codes and the written-back rows.
  always_comb begin
    col_w = cur_col_q - 1'b1;
    col_e = cur_col_q + 1'b1;
    for (int d = 0; d < 4; d++) begin
      nv[d] = nbr_valid(cur_row_q, cur_col_q, 2'(d), eff_rows, eff_cols);
    end
    nb_old[DIR_N] = row_n_q[cur_col_q[COL_AW-1:0]];
    nb_old[DIR_S] = row_s_q[cur_col_q[COL_AW-1:0]];
    nb_old[DIR_W] = row_c_q[col_w[COL_AW-1:0]];
    nb_old[DIR_E] = row_c_q[col_e[COL_AW-1:0]];
    // A refused move marks its target as wall; otherwise the reported walls are recorded,
    // leaving visited cells alone.
    for (int d = 0; d < 4; d++) begin
      nb_new[d] = nb_old[d];
      if (mode_q == MODE_IMP) begin
        if (nv[d] && (2'(d) == last_dir_q)) nb_new[d] = CELL_WALL;
      end else if (nv[d] && (nb_old[d] != CELL_VISITED)) begin
        nb_new[d] = walls_q[d] ? CELL_WALL : CELL_ROOM;
      end
      room[d] = nv[d] && (nb_new[d] == CELL_ROOM);
    end
    new_n = row_n_q;
    new_s = row_s_q;
    new_c = row_c_q;
    if (nv[DIR_N]) new_n[cur_col_q[COL_AW-1:0]] = nb_new[DIR_N];
    if (nv[DIR_S]) new_s[cur_col_q[COL_AW-1:0]] = nb_new[DIR_S];
    if ((mode_q == MODE_START) || (mode_q == MODE_OK)) begin
      new_c[cur_col_q[COL_AW-1:0]] = CELL_VISITED;
    end
    if (nv[DIR_W]) new_c[col_w[COL_AW-1:0]] = nb_new[DIR_W];
    if (nv[DIR_E]) new_c[col_e[COL_AW-1:0]] = nb_new[DIR_E];
    // First free room in the order north, south, west, east.
    found = |room;
    if (room[DIR_N]) begin
      pick = DIR_N;
    end else if (room[DIR_S]) begin
      pick = DIR_S;
    end else if (room[DIR_W]) begin
      pick = DIR_W;
    end else begin
      pick = DIR_E;
    end
  end

  // Explorer state, row buffers and the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      mode_q     <= MODE_START;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      last_dir_q <= DIR_N;
      pushed_q   <= 1'b0;
      count_q    <= '0;
      clr_cnt_q  <= '0;
    end else begin
      state_q <= state_d;

      // Clearing pass row counter.
      if ((state_q == S_INIT) || (state_q == S_CLEAR)) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
      end

      // Request acceptance: position, stack count and pushed flag settle here.
      if (accept) begin
        if (in_data_i.func == FUNC_START) begin
          mode_q    <= MODE_START;
          cur_row_q <= start_row_eff;
          cur_col_q <= start_col_eff;
          count_q   <= '0;
          pushed_q  <= 1'b0;
        end else begin
          case (in_data_i.response) inside
            RESP_IMPOSSIBLE: begin
              mode_q   <= MODE_IMP;
              pushed_q <= 1'b0;
              if (pushed_q && (count_q != '0)) count_q <= count_q - 1'b1;
            end
            RESP_OK, RESP_EXITED: begin
              mode_q <= (in_data_i.response == RESP_OK) ? MODE_OK : MODE_EXIT;
              if (tgt_ok) begin
                cur_row_q <= tgt_pos[2*POS_W-1:POS_W];
                cur_col_q <= tgt_pos[POS_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end

      // Move choice and stack update.
      if ((state_q == S_CALC) && (mode_q != MODE_EXIT)) begin
        pushed_q <= found && (count_q < STACK_CAP);
        if (found) begin
          last_dir_q <= pick;
          if (count_q < STACK_CAP) begin
            count_q <= count_q + 1'b1;
          end
        end else if (count_q != '0) begin
          count_q    <= count_q - 1'b1;
          last_dir_q <= stk_top_q ^ 2'b01;
        end
      end
    end
  end

  // Payload registers: request fields, row buffers and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      walls_q[DIR_N] <= in_data_i.north_wall;
      walls_q[DIR_S] <= in_data_i.south_wall;
      walls_q[DIR_W] <= in_data_i.west_wall;
      walls_q[DIR_E] <= in_data_i.east_wall;
    end
    if (state_q == S_RD_C) row_n_q <= map_rdata;
    if (state_q == S_RD_S) row_c_q <= map_rdata;
    if (state_q == S_CAP) begin
      row_s_q   <= map_rdata;
      stk_top_q <= stk_rdata;
    end
    if (state_q == S_CALC) begin
      row_n_q             <= new_n;
      row_c_q             <= new_c;
      row_s_q             <= new_s;
      nv_q                <= nv;
      res_q.pos_row       <= cur_row_q;
      res_q.pos_col       <= cur_col_q;
      if (mode_q == MODE_EXIT) begin
        res_q.status      <= STAT_EXITED;
        res_q.direction   <= DIR_N;
        res_q.backtracked <= 1'b0;
      end else if (found) begin
        res_q.status      <= STAT_MOVE;
        res_q.direction   <= pick;
        res_q.backtracked <= 1'b0;
      end else if (count_q != '0) begin
        res_q.status      <= STAT_MOVE;
        res_q.direction   <= stk_top_q ^ 2'b01;
        res_q.backtracked <= 1'b1;
      end else begin
        res_q.status      <= STAT_EXHAUSTED;
        res_q.direction   <= DIR_N;
        res_q.backtracked <= 1'b0;
      end
    end
    if (load_out) out_data_q <= res_q;
  end

  // Result slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Map memory: one row of cell codes per entry.
  dfs_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Backtrack stack of pushed directions; the top entry is read ahead of the choice.
  dfs_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (count_q[STK_AW-1:0]),
    .wdata_i (pick),
    .re_i    (stk_re),
    .raddr_i (STK_AW'(count_q - 1'b1)),
    .rdata_o (stk_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dfs_maze_explorer: directed and maze-driven random requests.
// Depends on dfs_pkg for the payload types and codes, and on the dfs_maze_explorer RTL.
module testbench;
  import dfs_pkg::*;

  localparam int CELLS        = MAX_ROWS * MAX_COLS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int WALK_PHASES  = 9;
  localparam int WALK_ITEMS   = 55;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;

  dfs_maze_explorer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Predicted state of the explorer: map, backtrack trail, position and registers.
  cell_e             map_q [CELLS];
  dir_e              trail_q [STACK_DEPTH];
  int unsigned       trail_cnt;
  int unsigned       at_row;
  int unsigned       at_col;
  dir_e              heading;
  bit                heading_pushed;
  logic [SIZE_W-1:0] rows_reg;
  logic [SIZE_W-1:0] cols_reg;
  logic [POS_W-1:0]  srow_reg;
  logic [POS_W-1:0]  scol_reg;

  // Hidden maze that the simulated robot answers from.
  bit                maze_wall [CELLS];
  int unsigned       exit_cell;

  out_item_t         expected_moves[$];
  out_item_t         last_res;
  out_item_t         want_res;
  int                errors     = 0;
  int                cycle_cnt  = 0;
  bit                tx_idle_en = 1'b1;
  bit                rx_idle_en = 1'b1;
  int                hold_reqs  = 0;
  int                hold_len   = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void maze_model_reset();
    foreach (map_q[i]) map_q[i] = CELL_UNKNOWN;
    foreach (trail_q[i]) trail_q[i] = DIR_N;
    trail_cnt      = 0;
    at_row         = 0;
    at_col         = 0;
    heading        = DIR_N;
    heading_pushed = 1'b0;
    rows_reg       = SIZE_W'(MAX_ROWS);
    cols_reg       = SIZE_W'(MAX_COLS);
    srow_reg       = '0;
    scol_reg       = '0;
  endfunction

  // Grid size in use: zero counts as one, oversize saturates.
  function automatic int unsigned rows_used();
    if (rows_reg == '0) return 1;
    return (rows_reg > ROWS_CAP) ? MAX_ROWS : rows_reg;
  endfunction

  function automatic int unsigned cols_used();
    if (cols_reg == '0) return 1;
    return (cols_reg > COLS_CAP) ? MAX_COLS : cols_reg;
  endfunction

  // Neighbor of (r,c) toward d; returns 0 when it falls off the grid.
  function automatic bit step_to(int unsigned r, int unsigned c, dir_e d,
                                 output int unsigned nr, output int unsigned nc);
    nr = r;
    nc = c;
    case (d)
      DIR_N: begin
        if (r == 0) return 1'b0;
        nr = r - 1;
      end
      DIR_S: nr = r + 1;
      DIR_W: begin
        if (c == 0) return 1'b0;
        nc = c - 1;
      end
      default: nc = c + 1;
    endcase
    return (nr < rows_used()) && (nc < cols_used());
  endfunction

  // Start cell after saturation to the last row and column.
  function automatic void start_cell(output int unsigned r, output int unsigned c);
    r = (srow_reg < rows_used()) ? srow_reg : rows_used() - 1;
    c = (scol_reg < cols_used()) ? scol_reg : cols_used() - 1;
  endfunction

  // Record reported neighbors of the current cell; visited cells keep their code.
  function automatic void note_neighbours(in_item_t item);
    logic [3:0]  walls;
    int unsigned nr;
    int unsigned nc;
    bit          ok;
    walls = {item.east_wall, item.west_wall, item.south_wall, item.north_wall};
    for (int d = 0; d < 4; d++) begin
      ok = step_to(at_row, at_col, dir_e'(d), nr, nc);
      if (ok && map_q[nr*MAX_COLS+nc] != CELL_VISITED)
        map_q[nr*MAX_COLS+nc] = walls[d] ? CELL_WALL : CELL_ROOM;
    end
  endfunction

  // Next move: first room in N,S,W,E order, else retrace the trail, else exhausted.
  function automatic out_item_t choose_next();
    out_item_t   res;
    int unsigned nr;
    int unsigned nc;
    bit          ok;
    dir_e        back;
    res         = '0;
    res.pos_row = POS_W'(at_row);
    res.pos_col = POS_W'(at_col);
    for (int d = 0; d < 4; d++) begin
      ok = step_to(at_row, at_col, dir_e'(d), nr, nc);
      if (ok && map_q[nr*MAX_COLS+nc] == CELL_ROOM) begin
        if (trail_cnt < STACK_DEPTH) begin
          trail_q[trail_cnt] = dir_e'(d);
          trail_cnt++;
          heading_pushed = 1'b1;
        end else begin
          heading_pushed = 1'b0;
        end
        heading       = dir_e'(d);
        res.status    = STAT_MOVE;
        res.direction = 2'(d);
        return res;
      end
    end
    if (trail_cnt > 0) begin
      trail_cnt--;
      back            = dir_e'(trail_q[trail_cnt] ^ 2'b01);
      heading         = back;
      heading_pushed  = 1'b0;
      res.status      = STAT_MOVE;
      res.direction   = back;
      res.backtracked = 1'b1;
      return res;
    end
    heading_pushed = 1'b0;
    res.status     = STAT_EXHAUSTED;
    return res;
  endfunction

  // Apply one request to the predicted state; returns 1 when it yields a result.
  function automatic bit predict_move(in_item_t item, output out_item_t res);
    int unsigned nr;
    int unsigned nc;
    bit          ok;
    res = '0;
    if (item.func == FUNC_START) begin
      foreach (map_q[i]) map_q[i] = CELL_UNKNOWN;
      trail_cnt      = 0;
      heading_pushed = 1'b0;
      start_cell(at_row, at_col);
      map_q[at_row*MAX_COLS+at_col] = CELL_VISITED;
      note_neighbours(item);
      res = choose_next();
      return 1'b1;
    end
    case (resp_e'(item.response))
      RESP_IMPOSSIBLE: begin
        ok = step_to(at_row, at_col, heading, nr, nc);
        if (ok) map_q[nr*MAX_COLS+nc] = CELL_WALL;
        // The refused step is taken back off the trail.
        if (heading_pushed && trail_cnt > 0) trail_cnt--;
        heading_pushed = 1'b0;
        res = choose_next();
        return 1'b1;
      end
      RESP_OK: begin
        ok = step_to(at_row, at_col, heading, nr, nc);
        if (ok) begin
          at_row = nr;
          at_col = nc;
        end
        map_q[at_row*MAX_COLS+at_col] = CELL_VISITED;
        note_neighbours(item);
        res = choose_next();
        return 1'b1;
      end
      RESP_EXITED: begin
        ok = step_to(at_row, at_col, heading, nr, nc);
        if (ok) begin
          at_row = nr;
          at_col = nc;
        end
        note_neighbours(item);
        res.status  = STAT_EXITED;
        res.pos_row = POS_W'(at_row);
        res.pos_col = POS_W'(at_col);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Wall bits around (r,c) from the hidden maze, indexed by direction; off-grid is random.
  function automatic logic [3:0] look_around(int unsigned r, int unsigned c);
    logic [3:0]  w;
    int unsigned nr;
    int unsigned nc;
    bit          ok;
    for (int d = 0; d < 4; d++) begin
      ok   = step_to(r, c, dir_e'(d), nr, nc);
      w[d] = ok ? maze_wall[nr*MAX_COLS+nc] : 1'($urandom_range(0, 1));
    end
    return w;
  endfunction

  // Request a robot in the hidden maze would send after the last result.
  function automatic in_item_t robot_reply();
    in_item_t    item;
    logic [6:0]  raw;
    logic [3:0]  w;
    int unsigned r;
    int unsigned c;
    bit          ok;
    raw  = 7'($urandom_range(0, 127));
    item = raw;
    if (last_res.status != STAT_MOVE) begin
      start_cell(r, c);
      item.func = FUNC_START;
    end else begin
      item.func = FUNC_MOVE;
      ok = step_to(at_row, at_col, heading, r, c);
      if (!ok || maze_wall[r*MAX_COLS+c]) begin
        item.response = RESP_IMPOSSIBLE;
        return item;
      end
      item.response = (r*MAX_COLS+c == exit_cell) ? RESP_EXITED : RESP_OK;
    end
    w               = look_around(r, c);
    item.north_wall = w[DIR_N];
    item.south_wall = w[DIR_S];
    item.west_wall  = w[DIR_W];
    item.east_wall  = w[DIR_E];
    return item;
  endfunction

  function automatic void build_maze(int unsigned wall_pct, bit with_exit);
    int unsigned r;
    int unsigned c;
    foreach (maze_wall[i]) maze_wall[i] = ($urandom_range(0, 99) < wall_pct);
    start_cell(r, c);
    maze_wall[r*MAX_COLS+c] = 1'b0;
    exit_cell = with_exit ? $urandom_range(0, rows_used()-1) * MAX_COLS
                            + $urandom_range(0, cols_used()-1) : CELLS;
  endfunction

  function automatic in_item_t pack_request(func_e f, resp_e r, logic [3:0] nswe);
    in_item_t item;
    item.func     = f;
    item.response = r;
    {item.north_wall, item.south_wall, item.west_wall, item.east_wall} = nswe;
    return item;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offer one request, with an optional idle burst ahead of it, and predict its result.
  task automatic send_request(in_item_t item);
    out_item_t res;
    bit        has;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    has = predict_move(item, res);
    if (has) begin
      expected_moves = {expected_moves, res};
      last_res = res;
    end
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_GRID_ROWS: rows_reg = value;
      CFG_GRID_COLS: cols_reg = value;
      CFG_START_ROW: srow_reg = value[POS_W-1:0];
      default:       scol_reg = value[POS_W-1:0];
    endcase
  endtask

  task automatic set_layout(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols,
                            logic [SIZE_W-1:0] srow, logic [SIZE_W-1:0] scol);
    wait_drained();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_START_ROW, srow);
    write_reg(CFG_START_COL, scol);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, or a long hold-off when one is requested.
  always @(negedge clk_i) begin : rx_side
    int hold_seen;
    int hold_left;
    int burst_left;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_moves.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want_res = expected_moves.pop_front();
        check_field("status", want_res.status, out_data.status);
        check_field("direction", want_res.direction, out_data.direction);
        check_field("backtracked", want_res.backtracked, out_data.backtracked);
        check_field("pos_row", want_res.pos_row, out_data.pos_row);
        check_field("pos_col", want_res.pos_col, out_data.pos_col);
      end
    end
  end

  // Hand-picked requests: start, every response, refused pushes and backtracks,
  // exhausted search, degenerate and oversized grids, and a start outside the grid.
  task automatic test_directed();
    send_request(pack_request(FUNC_START, RESP_IMPOSSIBLE, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_NOT_NOW, 4'b1111));
    send_request(pack_request(FUNC_MOVE, RESP_IMPOSSIBLE, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b1011));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b1111));
    send_request(pack_request(FUNC_MOVE, RESP_IMPOSSIBLE, 4'b1111));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_EXITED, 4'b0101));
    send_request(pack_request(FUNC_START, RESP_NOT_NOW, 4'b1111));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b1010));

    // Zero sizes collapse to a single cell, so every target is off the grid.
    set_layout(6'd0, 6'd0, 6'd0, 6'd0);
    send_request(pack_request(FUNC_START, RESP_OK, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_IMPOSSIBLE, 4'b1111));
    send_request(pack_request(FUNC_MOVE, RESP_EXITED, 4'b0000));

    // Oversized grid and start values with the upper bit set.
    set_layout(6'd63, 6'd63, 6'd63, 6'd63);
    send_request(pack_request(FUNC_START, RESP_EXITED, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_IMPOSSIBLE, 4'b0000));

    // Start beyond the grid saturates to the far corner.
    set_layout(6'd4, 6'd5, 6'd20, 6'd30);
    send_request(pack_request(FUNC_START, RESP_OK, 4'b0110));
    send_request(pack_request(FUNC_MOVE, RESP_IMPOSSIBLE, 4'b0000));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b0001));
    send_request(pack_request(FUNC_MOVE, RESP_NOT_NOW, 4'b0000));

    set_layout(6'd32, 6'd1, 6'd31, 6'd0);
    send_request(pack_request(FUNC_START, RESP_OK, 4'b0100));
    send_request(pack_request(FUNC_MOVE, RESP_OK, 4'b0100));
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    set_layout(6'd8, 6'd8, 6'd0, 6'd0);
    build_maze(20, 1'b0);
    last_res.status = STAT_EXHAUSTED;
    tx_idle_en      = 1'b0;
    wait_drained();
    hold_len = 300;
    hold_reqs++;
    repeat (15) send_request(robot_reply());
    tx_idle_en = 1'b1;
  endtask

  // Random mazes: mostly well-formed robot replies, the rest random requests.
  task automatic test_random_walks();
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] srow;
    logic [SIZE_W-1:0] scol;
    logic [6:0]        raw;
    in_item_t          item;
    for (int p = 0; p < WALK_PHASES; p++) begin
      case (p)
        0:       begin rows = 6'd32; cols = 6'd32; end
        1:       begin rows = $urandom_range(0, 1) ? 6'd63 : 6'd0; cols = 6'd2; end
        5: begin
          rows = SIZE_W'($urandom_range(1, 32));
          cols = SIZE_W'($urandom_range(33, 63));
        end
        default: begin
          rows = SIZE_W'($urandom_range(1, 8));
          cols = SIZE_W'($urandom_range(1, 8));
        end
      endcase
      srow = SIZE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 7));
      scol = SIZE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 7));
      set_layout(rows, cols, srow, scol);
      build_maze($urandom_range(15, 40), 1'(p % 2));
      last_res.status = STAT_EXHAUSTED;
      // Some phases run without idling; the last one has none at all.
      tx_idle_en = (p % 3) != 1 && p != WALK_PHASES - 1;
      rx_idle_en = (p % 4) != 2 && p != WALK_PHASES - 1;
      repeat (WALK_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          item = robot_reply();
        end else begin
          raw  = 7'($urandom_range(0, 127));
          item = raw;
        end
        send_request(item);
      end
    end
  endtask

  task automatic finish_run();
    wait_drained();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  endtask

  initial begin
    maze_model_reset();
    last_res = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_walks();
    finish_run();
  end

endmodule

// ===== dfs_maze_explorer.f =====
rtl/dfs_pkg.sv
rtl/dfs_ram.sv
rtl/dfs_maze_explorer.sv
tb/testbench.sv
